// ----- src/fault_indicator_frame_receiver_assert.svh -----
// Assertion macros for the fault indicator frame receiver checker.
// No dependencies; included by the checker file.
`ifndef FAULT_INDICATOR_FRAME_RECEIVER_ASSERT_SVH
`define FAULT_INDICATOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FIFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fifr_pkg.sv -----
// Shared constants and types for the fault indicator frame receiver.
// No dependencies; imported by the controller, the datapath, the top level and the checker.
package fifr_pkg;

  localparam int unsigned FRAME_LEN = 20;
  localparam int unsigned POS_W     = 5;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;

  localparam pos_t POS_HEAD   = 5'd0;
  localparam pos_t POS_SRC_HI = 5'd1;
  localparam pos_t POS_SRC_LO = 5'd2;
  localparam pos_t POS_DST_HI = 5'd3;
  localparam pos_t POS_DST_LO = 5'd4;
  localparam pos_t POS_FN_LO  = 5'd6;
  localparam pos_t POS_INFO1  = 5'd7;
  localparam pos_t POS_INFO2  = 5'd8;
  localparam pos_t POS_SUM    = 5'd18;
  localparam pos_t POS_TAIL   = 5'd19;
  localparam pos_t POS_LAST   = pos_t'(FRAME_LEN - 1);

  localparam byte_t HEAD_MARK  = 8'h28;
  localparam byte_t TAIL_MARK  = 8'h29;
  localparam byte_t FN_CURRENT = 8'h10;
  localparam byte_t FN_LINE    = 8'h20;
  localparam byte_t FN_FAULT   = 8'h90;
  localparam byte_t INFO1_MASK = 8'h0f;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_HEAD_ERR = 3'd1;
  localparam status_t ST_TAIL_ERR = 3'd2;
  localparam status_t ST_SUM_ERR  = 3'd3;
  localparam status_t ST_FN_ERR   = 3'd4;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_CURRENT = 2'd0;
  localparam kind_t KIND_LINE    = 2'd1;
  localparam kind_t KIND_FAULT   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic store_en;    // accept one rx byte into the frame store
    logic load_first;  // evaluate frame, load first result
    logic advance;     // current result taken, load next reply byte
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_end;   // next stored byte completes the frame
    logic last_result; // result on the output is the final one
  } sts_t;

endpackage

// ----- src/fault_indicator_frame_receiver.sv -----
// Top level of the fault indicator frame receiver.
// Depends on fifr_pkg, fifr_ctrl and fifr_dp.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_rx_byte
//   out_    | output    | out_valid/out_stall | status, address, kind, value,
//           |           |                     | fault code, reply byte, last
//
// Bytes 1 to 19 of a frame are taken one per cycle. The 20th byte is followed
// by a check state, then a bad frame gives one result and a good frame 20,
// one per cycle when out_stall is low. in_stall is high from the check state
// until the final result is taken. Results sit in output registers and hold
// while out_stall is high. rst_n is synchronous and clears the byte position
// and the controller.
module fault_indicator_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_sender_address,
  output logic [1:0]  out_report_kind,
  output logic [11:0] out_measured_value,
  output logic [7:0]  out_fault_code,
  output logic [7:0]  out_reply_byte,
  output logic        out_last_of_run
);
  import fifr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fifr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fifr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_rx_byte         (in_rx_byte),
    .out_status         (out_status),
    .out_sender_address (out_sender_address),
    .out_report_kind    (out_report_kind),
    .out_measured_value (out_measured_value),
    .out_fault_code     (out_fault_code),
    .out_reply_byte     (out_reply_byte),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

// ----- src/fifr_ctrl.sv -----
// Controller for the fault indicator frame receiver: collect, check, emit.
// Depends on fifr_pkg.
module fifr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  fifr_pkg::sts_t sts,
  output fifr_pkg::cmd_t cmd
);
  import fifr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.frame_end) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall && sts.last_result) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_EMIT);
  assign cmd.store_en   = (state_r == S_IDLE) && in_valid;
  assign cmd.load_first = (state_r == S_CHECK);
  assign cmd.advance    = (state_r == S_EMIT) && !out_stall && !sts.last_result;

endmodule

// ----- src/fifr_dp.sv -----
// Datapath for the fault indicator frame receiver: frame store, running
// checksum, frame checks and the registered result fields. Depends on fifr_pkg.
module fifr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  fifr_pkg::cmd_t    cmd,
  output fifr_pkg::sts_t    sts,
  input  logic [7:0]        in_rx_byte,
  output logic [2:0]        out_status,
  output logic [15:0]       out_sender_address,
  output logic [1:0]        out_report_kind,
  output logic [11:0]       out_measured_value,
  output logic [7:0]        out_fault_code,
  output logic [7:0]        out_reply_byte,
  output logic              out_last_of_run
);
  import fifr_pkg::*;

  byte_t   store_r [FRAME_LEN];
  pos_t    pos_r;
  pos_t    idx_r;
  byte_t   sum_r;
  logic    err_r;
  status_t status_r;
  logic [15:0] addr_r;
  kind_t   kind_r;
  logic [11:0] value_r;
  byte_t   fault_r;
  byte_t   reply_r;

  status_t chk_status;
  kind_t   chk_kind;
  logic    fn_known;
  pos_t    rd_idx;
  byte_t   rd_byte;
  byte_t   info1_lo;

  // reply frame: addresses swapped, function low and checksum bumped
  always_comb begin
    case (rd_idx)
      POS_SRC_HI: rd_byte = store_r[POS_DST_HI];
      POS_SRC_LO: rd_byte = store_r[POS_DST_LO];
      POS_DST_HI: rd_byte = store_r[POS_SRC_HI];
      POS_DST_LO: rd_byte = store_r[POS_SRC_LO];
      POS_FN_LO:  rd_byte = store_r[POS_FN_LO] + 8'd1;
      POS_SUM:    rd_byte = store_r[POS_SUM] + 8'd1;
      default:    rd_byte = store_r[rd_idx];
    endcase
  end

  assign rd_idx = cmd.load_first ? POS_HEAD : pos_t'(idx_r + pos_t'(1));

  always_comb begin
    fn_known = 1'b1;
    case (store_r[POS_FN_LO])
      FN_CURRENT: chk_kind = KIND_CURRENT;
      FN_LINE:    chk_kind = KIND_LINE;
      FN_FAULT:   chk_kind = KIND_FAULT;
      default: begin
        chk_kind = KIND_CURRENT;
        fn_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (store_r[POS_HEAD] != HEAD_MARK) begin
      chk_status = ST_HEAD_ERR;
    end else if (store_r[POS_TAIL] != TAIL_MARK) begin
      chk_status = ST_TAIL_ERR;
    end else if (sum_r != store_r[POS_SUM]) begin
      chk_status = ST_SUM_ERR;
    end else if (!fn_known) begin
      chk_status = ST_FN_ERR;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign info1_lo = store_r[POS_INFO1] & INFO1_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.store_en) begin
      pos_r <= (pos_r == POS_LAST) ? '0 : pos_t'(pos_r + pos_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_en) begin
      store_r[pos_r] <= in_rx_byte;
      // checksum covers bytes 1..17, built as they arrive
      if (pos_r == POS_SRC_HI) begin
        sum_r <= in_rx_byte;
      end else if (pos_r > POS_SRC_HI && pos_r < POS_SUM) begin
        sum_r <= sum_r + in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      idx_r    <= '0;
      status_r <= chk_status;
      err_r    <= (chk_status != ST_OK);
      if (chk_status == ST_OK) begin
        addr_r  <= {store_r[POS_SRC_HI], store_r[POS_SRC_LO]};
        kind_r  <= chk_kind;
        value_r <= (chk_kind == KIND_FAULT) ? 12'd0
                                            : {info1_lo[3:0], store_r[POS_INFO2]};
        fault_r <= (chk_kind == KIND_FAULT) ? store_r[POS_INFO2] : 8'd0;
        reply_r <= rd_byte;
      end else begin
        addr_r  <= '0;
        kind_r  <= KIND_CURRENT;
        value_r <= '0;
        fault_r <= '0;
        reply_r <= '0;
      end
    end else if (cmd.advance) begin
      idx_r   <= rd_idx;
      reply_r <= rd_byte;
    end
  end

  assign sts.frame_end   = (pos_r == POS_LAST);
  assign sts.last_result = err_r || (idx_r == POS_LAST);

  assign out_status         = status_r;
  assign out_sender_address = addr_r;
  assign out_report_kind    = kind_r;
  assign out_measured_value = value_r;
  assign out_fault_code     = fault_r;
  assign out_reply_byte     = reply_r;
  assign out_last_of_run    = sts.last_result;

endmodule

// ----- src/fifr_checker.sv -----
// Port-level checks for the fault indicator frame receiver, bound to the top.
// Depends on fifr_pkg and fault_indicator_frame_receiver_assert.svh.
`include "fault_indicator_frame_receiver_assert.svh"

module fifr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [7:0]  out_reply_byte,
  input logic        out_last_of_run
);
  import fifr_pkg::*;

  // a stalled result holds
  `FIFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_reply_byte) && $stable(out_status), "stalled result changed")

  // no byte is taken while results are pending
  `FIFR_ASSERT_NOW(a_in_blocked, clk, rst_n, out_valid, in_stall, "input open during result drain")

  // a bad frame gives one result only, with zero reply byte
  `FIFR_ASSERT_NOW(a_err_single, clk, rst_n, out_valid && out_status != ST_OK, out_last_of_run && out_reply_byte == 8'd0, "error result not final")

  // after the final result is taken, nothing more follows at once
  `FIFR_ASSERT_NEXT(a_run_end, clk, rst_n, out_valid && !out_stall && out_last_of_run, !out_valid, "result after end of run")

endmodule

bind fault_indicator_frame_receiver fifr_checker u_fifr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_reply_byte  (out_reply_byte),
  .out_last_of_run (out_last_of_run)
);
